/* src/snrei_pkg.sv */
// ----------------------------------------------------------------------------
// snrei_pkg
// Shared types and constants for the SNR to error-rate interpolator.
// ----------------------------------------------------------------------------
package snrei_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = 6;
  localparam int unsigned CntW       = 7;
  localparam int unsigned SnrW       = 16;
  localparam int unsigned ValW       = 17;
  localparam int unsigned NbitsW     = 24;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned BitW       = 5;
  localparam logic [ValW-1:0] OneQ   = ValW'(1) << FracBits;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic RegIsBer = 1'b0;
  localparam logic RegCount = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [IdxW-1:0]   entry_index;
    logic signed [SnrW-1:0] entry_snr;
    logic [ValW-1:0]   entry_value;
    logic signed [SnrW-1:0] query_snr;
    logic [NbitsW-1:0] bit_count;
  } in_item_t;

  typedef struct packed {
    logic [ValW-1:0] error_rate;
    logic [ValW-1:0] success_rate;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;       // capture input item
    logic            wr_entry;   // write table entry
    logic            rd_issue;   // read table at rd_addr
    logic [IdxW-1:0] rd_addr;
    logic            chk_first;  // compare against entry 0 (data valid)
    logic            chk_last;   // compare against last entry
    logic            chk_scan;   // scan step: rd data is entry i
    logic            mul_start;  // form numerator product
    logic            div_start;
    logic            div_step;
    logic            div_done;   // form interpolated value
    logic            pow_init;
    logic            pow_step;   // one square-and-multiply step
    logic [BitW-1:0] pow_bit;
    logic            fin_write;  // zero result
    logic            fin_empty;  // value register to 1.0
    logic            fin_value;  // result from value register
    logic            fin_pow;    // result from power register
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic hit_low;    // query at or below first entry
    logic hit_high;   // query at or above last entry
    logic scan_hit;   // q <= snr[i]
    logic deg;        // d <= 0
  } sts_t;

endpackage

/* src/snrei_datapath.sv */
// ----------------------------------------------------------------------------
// snrei_datapath
// Table memory, interpolation arithmetic, serial divider and power unit.
// ----------------------------------------------------------------------------
module snrei_datapath (
  input  logic                 clk_i,
  input  snrei_pkg::cmd_t      cmd_i,
  input  snrei_pkg::in_item_t  item_i,
  output snrei_pkg::sts_t      sts_o,
  output snrei_pkg::out_item_t res_o
);

  localparam int unsigned ValW = snrei_pkg::ValW;
  localparam int unsigned SnrW = snrei_pkg::SnrW;

  logic signed [SnrW-1:0] snr_mem [snrei_pkg::TableDepth];
  logic [ValW-1:0]        val_mem [snrei_pkg::TableDepth];
  logic signed [SnrW-1:0] rd_snr_q;
  logic [ValW-1:0]        rd_val_q;

  snrei_pkg::in_item_t    item_q;
  logic signed [SnrW-1:0] s0_q;
  logic [ValW-1:0]        v0_q;
  logic signed [SnrW:0]   d_q;
  logic signed [35:0]     num_q;
  logic [35:0]            rem_q, quo_q;
  logic [SnrW:0]          dabs_q;
  logic                   neg_q;
  logic [ValW-1:0]        val_q;
  logic [ValW-1:0]        p_q, r_q;
  logic                   deg_q;
  snrei_pkg::out_item_t   res_q;

  logic [ValW-1:0]        wval;
  logic signed [SnrW:0]   dq;
  logic signed [ValW:0]   dv;
  logic [36:0]            trial;
  logic [35:0]            nabs;
  logic signed [36:0]     quo_s;
  logic signed [ValW+1:0] interp;
  logic [2*ValW-1:0]      rp, pp;

  assign wval = (item_q.entry_value > snrei_pkg::OneQ) ? snrei_pkg::OneQ
                                                       : item_q.entry_value;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry) begin
      snr_mem[item_q.entry_index] <= item_q.entry_snr;
      val_mem[item_q.entry_index] <= wval;
    end
    if (cmd_i.rd_issue) begin
      rd_snr_q <= snr_mem[cmd_i.rd_addr];
      rd_val_q <= val_mem[cmd_i.rd_addr];
    end
  end

  assign dq    = (SnrW+1)'(item_q.query_snr) - (SnrW+1)'(s0_q);
  assign dv    = (ValW+1)'(signed'({1'b0, rd_val_q})) - (ValW+1)'(signed'({1'b0, v0_q}));
  assign nabs  = num_q[35] ? 36'(-num_q) : 36'(num_q);
  assign trial = {rem_q, quo_q[35]} - 37'(dabs_q);
  assign quo_s = neg_q ? -37'(quo_q) : 37'(quo_q);
  assign interp = (ValW+2)'(signed'({1'b0, v0_q})) + (ValW+2)'(quo_s);
  assign rp    = 34'(r_q) * 34'(p_q);
  assign pp    = 34'(p_q) * 34'(p_q);

  assign sts_o.is_query = item_q.operation == snrei_pkg::OpQuery;
  assign sts_o.hit_low  = item_q.query_snr <= rd_snr_q;
  assign sts_o.hit_high = item_q.query_snr >= rd_snr_q;
  assign sts_o.scan_hit = item_q.query_snr <= rd_snr_q;
  assign sts_o.deg      = deg_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    if (cmd_i.chk_first || cmd_i.chk_last) val_q <= rd_val_q;
    if (cmd_i.chk_scan) begin
      s0_q <= rd_snr_q;
      v0_q <= rd_val_q;
    end
    if (cmd_i.mul_start) begin
      d_q   <= (SnrW+1)'(rd_snr_q) - (SnrW+1)'(s0_q);
      deg_q <= ((SnrW+1)'(rd_snr_q) - (SnrW+1)'(s0_q)) <= 0;
      num_q <= 36'(dq) * 36'(dv);
      val_q <= rd_val_q;
    end
    if (cmd_i.div_start) begin
      dabs_q <= d_q[SnrW:0];
      neg_q  <= num_q[35];
      quo_q  <= nabs;
      rem_q  <= '0;
    end
    if (cmd_i.div_step) begin
      if (!trial[36]) begin
        rem_q <= trial[35:0];
        quo_q <= {quo_q[34:0], 1'b1};
      end else begin
        rem_q <= {rem_q[34:0], quo_q[35]};
        quo_q <= {quo_q[34:0], 1'b0};
      end
    end
    if (cmd_i.div_done && !deg_q) begin
      val_q <= interp[ValW-1:0];
    end
    if (cmd_i.pow_init) begin
      p_q <= snrei_pkg::OneQ - ((val_q > snrei_pkg::OneQ) ? snrei_pkg::OneQ : val_q);
      r_q <= snrei_pkg::OneQ;
    end
    if (cmd_i.pow_step) begin
      if (item_q.bit_count[cmd_i.pow_bit]) r_q <= ValW'(rp >> snrei_pkg::FracBits);
      p_q <= ValW'(pp >> snrei_pkg::FracBits);
    end
    if (cmd_i.fin_write) res_q <= '0;
    if (cmd_i.fin_empty) val_q <= snrei_pkg::OneQ;
    if (cmd_i.fin_value) begin
      res_q.error_rate   <= (val_q > snrei_pkg::OneQ) ? snrei_pkg::OneQ : val_q;
      res_q.success_rate <= snrei_pkg::OneQ -
                            ((val_q > snrei_pkg::OneQ) ? snrei_pkg::OneQ : val_q);
    end
    if (cmd_i.fin_pow) begin
      res_q.error_rate   <= snrei_pkg::OneQ - ((r_q > snrei_pkg::OneQ) ? snrei_pkg::OneQ : r_q);
      res_q.success_rate <= (r_q > snrei_pkg::OneQ) ? snrei_pkg::OneQ : r_q;
    end
  end

  assign res_o = res_q;

endmodule

/* src/snrei_ctrl.sv */
// ----------------------------------------------------------------------------
// snrei_ctrl
// Sequencer for table writes, the table scan, division and power steps.
// ----------------------------------------------------------------------------
module snrei_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  logic                 is_ber_i,
  input  logic [snrei_pkg::CntW-1:0] count_i,
  input  snrei_pkg::sts_t      sts_i,
  output snrei_pkg::cmd_t      cmd_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDec   = 4'd1;
  localparam logic [3:0] StFirst = 4'd2;
  localparam logic [3:0] StLast  = 4'd3;
  localparam logic [3:0] StScan  = 4'd4;
  localparam logic [3:0] StMul   = 4'd5;
  localparam logic [3:0] StDivS  = 4'd6;
  localparam logic [3:0] StDiv   = 4'd7;
  localparam logic [3:0] StDivE  = 4'd8;
  localparam logic [3:0] StPowI  = 4'd9;
  localparam logic [3:0] StPow   = 4'd10;
  localparam logic [3:0] StFin   = 4'd11;
  localparam logic [3:0] StOut   = 4'd12;
  localparam logic [3:0] StRd0   = 4'd13;

  localparam int unsigned IdxW = snrei_pkg::IdxW;

  logic [3:0]      state_q, state_d;
  logic [IdxW:0]   i_q, i_d;
  logic [5:0]      k_q, k_d;
  logic [IdxW:0]   n_eff;
  logic            acc;

  assign n_eff = (count_i > snrei_pkg::CntW'(snrei_pkg::TableDepth))
                 ? (IdxW+1)'(snrei_pkg::TableDepth) : count_i[IdxW:0];
  assign acc        = in_valid_i && state_q == StIdle;
  assign in_stall_o = state_q != StIdle;
  assign out_valid_o = state_q == StOut;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    k_d     = k_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.load = acc;
        if (acc) state_d = StDec;
      end
      StDec: begin
        if (!sts_i.is_query) begin
          cmd_o.wr_entry = 1'b1;
          cmd_o.fin_write = 1'b1;
          state_d = StOut;
        end else if (n_eff == '0) begin
          cmd_o.fin_empty = 1'b1;
          state_d = StFin;
        end else begin
          cmd_o.rd_issue = 1'b1;
          cmd_o.rd_addr  = '0;
          state_d = StFirst;
        end
      end
      StFirst: begin
        cmd_o.chk_first = 1'b1;
        if (sts_i.hit_low) begin
          state_d = StFin;
        end else begin
          cmd_o.rd_issue = 1'b1;
          cmd_o.rd_addr  = IdxW'(n_eff - 1'b1);
          state_d = StLast;
        end
      end
      StLast: begin
        cmd_o.chk_last = 1'b1;
        if (sts_i.hit_high) begin
          state_d = StFin;
        end else begin
          cmd_o.rd_issue = 1'b1;
          cmd_o.rd_addr  = '0;
          state_d = StRd0;
        end
      end
      StRd0: begin
        cmd_o.chk_scan = 1'b1;
        cmd_o.rd_issue = 1'b1;
        cmd_o.rd_addr  = IdxW'(1);
        i_d = (IdxW+1)'(1);
        state_d = StScan;
      end
      StScan: begin
        if (sts_i.scan_hit) begin
          cmd_o.mul_start = 1'b1;
          state_d = StMul;
        end else if (i_q + 1'b1 >= n_eff) begin
          state_d = StFin;
        end else begin
          cmd_o.chk_scan = 1'b1;
          cmd_o.rd_issue = 1'b1;
          cmd_o.rd_addr  = IdxW'(i_q + 1'b1);
          i_d = i_q + 1'b1;
        end
      end
      StMul: begin
        if (sts_i.deg) begin
          state_d = StFin;
        end else begin
          cmd_o.div_start = 1'b1;
          k_d = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        k_d = k_q + 1'b1;
        if (k_q == 6'd35) state_d = StDivE;
      end
      StDivE: begin
        cmd_o.div_done = 1'b1;
        state_d = StFin;
      end
      StFin: begin
        if (is_ber_i) begin
          cmd_o.pow_init = 1'b1;
          k_d = '0;
          state_d = StPow;
        end else begin
          cmd_o.fin_value = 1'b1;
          state_d = StOut;
        end
      end
      StPow: begin
        cmd_o.pow_step = 1'b1;
        cmd_o.pow_bit  = k_q[snrei_pkg::BitW-1:0];
        k_d = k_q + 1'b1;
        if (k_q == 6'(snrei_pkg::NbitsW - 1)) state_d = StPowI;
      end
      StPowI: begin
        cmd_o.fin_pow = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      i_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      k_q     <= k_d;
    end
  end

endmodule

/* src/snr_error_rate_interpolator.sv */
// ----------------------------------------------------------------------------
// snr_error_rate_interpolator
// Piecewise linear SNR to error-rate table with optional chunk error rate.
// ----------------------------------------------------------------------------
// Channel | Signals                          | Direction
// in      | in_valid_i, in_stall_o, in_i     | transaction into the block
// out     | out_valid_o, out_stall_i, out_o  | transaction out of the block
// cfg     | psel .. pwdata, prdata, pready    | register access
//
// A query runs a table scan (one memory read per entry), a serial division
// and, in BER mode, square-and-multiply steps. One transaction is in flight
// at a time. Reset clears control and register state only; the table is
// undefined until written. A result is held while out_stall_i is high.
module snr_error_rate_interpolator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  snrei_pkg::in_item_t  in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output snrei_pkg::out_item_t out_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic                          is_ber_q;
  logic [snrei_pkg::CntW-1:0]    count_q;
  snrei_pkg::cmd_t               cmd;
  snrei_pkg::sts_t               sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_ber_q <= 1'b0;
      count_q  <= '0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == snrei_pkg::RegIsBer) is_ber_q <= pwdata[0];
      else                                 count_q  <= pwdata[snrei_pkg::CntW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == snrei_pkg::RegIsBer) prdata = 32'(is_ber_q);
      else                                 prdata = 32'(count_q);
    end
  end

  snrei_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_ber_i    (is_ber_q),
    .count_i     (count_q),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  snrei_datapath u_dp (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .item_i         (in_i),
    .sts_o          (sts),
    .res_o          (out_o)
  );

endmodule
